>>> rtl/ipsb_pkg.sv
// ----------------------------------------------------------------------------
// IP strike ban table package
// Sizes, hash constants and the controller state type shared by the block.
// ----------------------------------------------------------------------------
package ipsb_pkg;

  // The table depth is a power of two, so the home slot is the low hash bits.
  localparam int IDX_W      = 5;
  localparam int TABLE_SIZE = 2 ** IDX_W;

  localparam int IP_W      = 32;
  localparam int STRIKE_W  = 7;
  localparam int ENTRY_W   = IP_W + STRIKE_W;

  localparam logic [31:0]         FNV_BASIS     = 32'd2166136261;
  localparam logic [31:0]         FNV_PRIME     = 32'd16777619;
  localparam logic [STRIKE_W-1:0] STRIKE_MAX    = 7'd127;
  localparam logic [STRIKE_W-1:0] THRESH_RESET  = 7'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } ipsb_state_t;

endpackage

>>> rtl/ipsb_ifs.sv
// ----------------------------------------------------------------------------
// IP strike ban table channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ipsb_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] client_ip;
  logic        target_found;

  modport source (output valid, output client_ip, output target_found, input ready);
  modport sink   (input valid, input client_ip, input target_found, output ready);
endinterface

interface ipsb_res_if;
  logic       valid;
  logic       ready;
  logic       denied;
  logic [6:0] strikes_now;
  logic       table_full;

  modport source (output valid, output denied, output strikes_now, output table_full,
                  input ready);
  modport sink   (input valid, input denied, input strikes_now, input table_full,
                  output ready);
endinterface

interface ipsb_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ipsb_ram.sv
// ----------------------------------------------------------------------------
// IP strike ban table RAM
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ipsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ip_strike_ban_table_unit.sv
// ----------------------------------------------------------------------------
// IP strike ban table unit
// Open-addressed table of client addresses and strike counts, one request
// beat in and one result beat out per request.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per client request (client_ip, target_found). res
//   returns one beat per request (denied, strikes_now, table_full). cfg
//   writes ban_threshold and is always ready; write it only while idle.
//   A request runs from acceptance to its result beat through the FNV-1a
//   hash, one byte at a time through a single 32x32 multiplier, then one
//   table read per slot through the single read port of the table RAM, a
//   drain state for the last read and a write-back state that also loads
//   the result register. One request is processed at a time; req is ready
//   whenever the controller is idle, even while a finished result beat
//   still waits in the output register. The next request is taken the
//   cycle after the write-back at the earliest, so no request is accepted
//   before the last one has been written back. If res stalls, the next
//   request runs up to its write-back and waits there until the output
//   register is free. Reset clears every slot valid bit at once, empties
//   the output register and returns ban_threshold to 3; the table RAM
//   itself is not cleared.
// ----------------------------------------------------------------------------
module ip_strike_ban_table_unit (
  input logic       clk,
  input logic       rst,
  ipsb_req_if.sink   req,
  ipsb_res_if.source res,
  ipsb_cfg_if.sink   cfg
);
  import ipsb_pkg::*;

  ipsb_state_t state, state_next;

  logic [IP_W-1:0]     ip_r;
  logic                tf_r;
  logic [31:0]         hash;
  logic [1:0]          byte_cnt;
  logic [IDX_W-1:0]    probe_idx;
  logic [IDX_W-1:0]    scan_cnt;
  logic [STRIKE_W-1:0] threshold;
  logic [TABLE_SIZE-1:0] slot_vld;

  logic                chk_v;
  logic                chk_vld;
  logic [IDX_W-1:0]    chk_idx;

  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [STRIKE_W-1:0] hit_strk;
  logic                have_free;
  logic [IDX_W-1:0]    free_idx;

  logic                out_vld;
  logic                out_denied;
  logic [STRIKE_W-1:0] out_strikes;
  logic                out_full;
  logic                out_free;

  logic                ram_we;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [7:0]          hash_byte;
  logic [31:0]         hash_mix;
  logic [31:0]         hash_next;

  logic                upd_denied;
  logic [STRIKE_W-1:0] upd_strikes;
  logic                upd_full;
  logic                upd_write;
  logic                upd_alloc;
  logic [IDX_W-1:0]    upd_idx;
  logic                in_acc;

  ipsb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(probe_idx),
    .rdata(ram_rdata)
  );

  assign in_acc   = req.valid && req.ready;
  assign out_free = !out_vld || res.ready;
  assign cfg.ready = 1'b1;

  // Bytes enter the hash most significant first.
  assign hash_byte = 8'(ip_r >> {~byte_cnt, 3'b000});
  assign hash_mix  = hash ^ {24'd0, hash_byte};
  assign hash_next = hash_mix * FNV_PRIME;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = ST_HASH;
      ST_HASH:   if (byte_cnt == 2'd3) state_next = ST_SCAN;
      ST_SCAN:   if (scan_cnt == IDX_W'(TABLE_SIZE - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready = 1'b0;
    ram_re    = 1'b0;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_SCAN:  ram_re    = 1'b1;
      default: begin
        req.ready = 1'b0;
        ram_re    = 1'b0;
      end
    endcase
  end

  // Decision once the whole probe sequence has been seen.
  always_comb begin
    upd_denied  = 1'b0;
    upd_strikes = '0;
    upd_full    = 1'b0;
    upd_write   = 1'b0;
    upd_alloc   = 1'b0;
    upd_idx     = hit_idx;
    if (hit) begin
      upd_strikes = hit_strk;
      if (hit_strk >= threshold) begin
        upd_denied = 1'b1;
      end else if (!tf_r) begin
        upd_write = 1'b1;
        if (hit_strk != STRIKE_MAX) begin
          upd_strikes = hit_strk + 7'd1;
        end
      end
    end else if (!tf_r) begin
      if (have_free) begin
        upd_write   = 1'b1;
        upd_alloc   = 1'b1;
        upd_idx     = free_idx;
        upd_strikes = 7'd1;
      end else begin
        upd_full = 1'b1;
      end
    end
  end

  // Reads and the write-back never overlap, as the scan finishes before the
  // update state, so no forwarding path is needed.
  assign ram_we    = (state == ST_UPDATE) && out_free && upd_write;
  assign ram_waddr = upd_idx;
  assign ram_wdata = {ip_r, upd_strikes};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot_vld  <= '0;
      threshold <= THRESH_RESET;
      out_vld   <= 1'b0;
      chk_v     <= 1'b0;
    end else begin
      state <= state_next;
      chk_v <= ram_re;
      if (cfg.valid && cfg.ready) begin
        threshold <= cfg.data;
      end
      if (ram_we && upd_alloc) begin
        slot_vld[upd_idx] <= 1'b1;
      end
      if (state == ST_UPDATE && out_free) begin
        out_vld <= 1'b1;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ip_r      <= req.client_ip;
      tf_r      <= req.target_found;
      hash      <= FNV_BASIS;
      byte_cnt  <= '0;
      scan_cnt  <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end
    if (state == ST_HASH) begin
      hash     <= hash_next;
      byte_cnt <= byte_cnt + 2'd1;
      if (byte_cnt == 2'd3) begin
        probe_idx <= hash_next[IDX_W-1:0];
      end
    end
    if (state == ST_SCAN) begin
      probe_idx <= probe_idx + IDX_W'(1);
      scan_cnt  <= scan_cnt + IDX_W'(1);
      chk_vld   <= slot_vld[probe_idx];
      chk_idx   <= probe_idx;
    end
    // Compare the slot read in the previous cycle; the first match and the
    // first empty slot along the probe sequence are kept.
    if (chk_v) begin
      if (chk_vld) begin
        if (!hit && ram_rdata[ENTRY_W-1:STRIKE_W] == ip_r) begin
          hit      <= 1'b1;
          hit_idx  <= chk_idx;
          hit_strk <= ram_rdata[STRIKE_W-1:0];
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_idx  <= chk_idx;
      end
    end
    if (state == ST_UPDATE && out_free) begin
      out_denied  <= upd_denied;
      out_strikes <= upd_strikes;
      out_full    <= upd_full;
    end
  end

  assign res.valid       = out_vld;
  assign res.denied      = out_denied;
  assign res.strikes_now = out_strikes;
  assign res.table_full  = out_full;

  a_accept_starts_hash: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_HASH)
    else $error("accepted request did not start hashing");

  a_write_only_on_update: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_UPDATE) && out_free)
    else $error("table written outside write-back");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && hit) |-> slot_vld[hit_idx])
    else $error("hit recorded on an empty slot");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state == ST_UPDATE))
    else $error("result beat appeared without a write-back");

  a_denied_not_full: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_denied && out_full))
    else $error("result both denied and table full");

endmodule

>>> bench/tb_ip_strike_ban_table_unit.sv
// ----------------------------------------------------------------------------
// IP strike ban table unit testbench
// A short table of hand-picked requests and threshold writes comes first,
// followed by several random phases with different thresholds and address
// pools. The final phase floods the table with fresh addresses until it is
// full. Every result beat is checked against its typed verdict or a local model.
// ----------------------------------------------------------------------------
module tb_ip_strike_ban_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ipsb_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int IDLE_PCT    = 35;
  localparam int N_ROWS      = 24;

  typedef struct packed {
    logic                denied;
    logic [STRIKE_W-1:0] strikes_now;
    logic                table_full;
  } verdict_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [IP_W-1:0] ip;
    logic            found;
    logic            typed;
    verdict_t        want;
  } step_row_t;

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   cycle_count;

  ipsb_req_if req_ch ();
  ipsb_res_if res_ch ();
  ipsb_cfg_if cfg_ch ();

  ip_strike_ban_table_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Local copy of the table and the threshold register.
  logic                slot_used [TABLE_SIZE];
  logic [IP_W-1:0]     slot_ip   [TABLE_SIZE];
  logic [STRIKE_W-1:0] slot_cnt  [TABLE_SIZE];
  logic [STRIKE_W-1:0] threshold_mirror;

  verdict_t        pending_verdicts [$];
  verdict_t        want_v;
  logic [IP_W-1:0] known_ips [$];
  step_row_t       directed_rows [N_ROWS];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] fnv1a_ip(input logic [IP_W-1:0] ip);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int b = 3; b >= 0; b--) begin
      h = h ^ {24'd0, ip[8*b +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic verdict_t strike_verdict(input logic [IP_W-1:0] ip, input logic found);
    logic [31:0]      h;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic             hit;
    logic             have_free;
    verdict_t         v;
    h         = fnv1a_ip(ip);
    idx       = h[IDX_W-1:0];
    hit       = 1'b0;
    have_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    v         = '0;
    // The whole probe sequence is scanned; the index wraps at the table size.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (slot_used[idx]) begin
        if (!hit && slot_ip[idx] == ip) begin
          hit     = 1'b1;
          hit_idx = idx;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = idx;
      end
      idx = idx + IDX_W'(1);
    end
    if (hit) begin
      v.strikes_now = slot_cnt[hit_idx];
      if (v.strikes_now >= threshold_mirror) begin
        v.denied = 1'b1;
      end else if (!found) begin
        if (v.strikes_now < STRIKE_MAX) v.strikes_now = v.strikes_now + 7'd1;
        slot_cnt[hit_idx] = v.strikes_now;
      end
    end else if (!found) begin
      if (have_free) begin
        slot_used[free_idx] = 1'b1;
        slot_ip[free_idx]   = ip;
        slot_cnt[free_idx]  = 7'd1;
        v.strikes_now       = 7'd1;
      end else begin
        v.table_full = 1'b1;
      end
    end
    return v;
  endfunction

  // Valid is only ever changed once per falling edge, so a beat that follows
  // another without a gap keeps valid high throughout.
  task automatic send_req(input logic [IP_W-1:0] ip, input logic found,
                          input logic typed, input verdict_t typed_v);
    verdict_t v;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.client_ip    <= ip;
    req_ch.target_found <= found;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    v = strike_verdict(ip, found);
    pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [STRIKE_W-1:0] thr);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= thr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    threshold_mirror = thr;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Requests come from a small pool so that counts climb and bans bite, but
  // 15 percent revisit older addresses and fresh ones fill up the table.
  task automatic run_phase(input logic [STRIKE_W-1:0] thr, input int pool_n,
                           input int n_items, input int miss_pct, input int fresh_pct);
    logic [IP_W-1:0] pool [$];
    logic [IP_W-1:0] ip;
    int              pick;
    write_threshold(thr);
    repeat (pool_n) begin
      ip = $urandom;
      pool.push_back(ip);
      known_ips.push_back(ip);
    end
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < fresh_pct) begin
        ip = $urandom;
        known_ips.push_back(ip);
      end else if (pick < fresh_pct + 15) begin
        ip = known_ips[$urandom_range(known_ips.size() - 1)];
      end else begin
        ip = pool[$urandom_range(pool.size() - 1)];
      end
      send_req(ip, $urandom_range(99) >= miss_pct, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
      end else begin
        want_v = pending_verdicts.pop_front();
        if (res_ch.denied !== want_v.denied) begin
          $error("denied: expected %0d, got %0d", want_v.denied, res_ch.denied);
          errors++;
        end
        if (res_ch.strikes_now !== want_v.strikes_now) begin
          $error("strikes_now: expected %0d, got %0d", want_v.strikes_now,
                 res_ch.strikes_now);
          errors++;
        end
        if (res_ch.table_full !== want_v.table_full) begin
          $error("table_full: expected %0d, got %0d", want_v.table_full,
                 res_ch.table_full);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** ip_strike_ban_table_unit: FAILED **");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    errors              = 0;
    req_ch.valid        = 1'b0;
    req_ch.client_ip    = '0;
    req_ch.target_found = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    res_ch.ready        = 1'b0;
    threshold_mirror    = THRESH_RESET;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_ip[i]   = '0;
      slot_cnt[i]  = '0;
    end

    // kind, address or threshold, target_found, typed, {denied, strikes, full}
    directed_rows = '{
      '{ROW_REQ, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 7'd0, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 7'd1, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 7'd2, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 7'd2, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 7'd3, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 7'd3, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 7'd3, 1'b0}},
      '{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 7'd1, 1'b0}},
      '{ROW_REQ, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 7'd1, 1'b0}},
      '{ROW_REQ, 32'h8000_0001, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_REQ, 32'h00FF_00FF, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_CFG, 32'd0,         1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 7'd3, 1'b0}},
      '{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, 7'd1, 1'b0}},
      '{ROW_REQ, 32'h1234_5678, 1'b0, 1'b1, '{1'b0, 7'd1, 1'b0}},
      '{ROW_REQ, 32'h1234_5678, 1'b1, 1'b1, '{1'b1, 7'd1, 1'b0}},
      '{ROW_REQ, 32'h00FF_00FF, 1'b1, 1'b1, '{1'b0, 7'd0, 1'b0}},
      '{ROW_CFG, 32'd127,       1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 7'd4, 1'b0}},
      '{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 7'd2, 1'b0}},
      '{ROW_REQ, 32'h8000_0001, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_CFG, 32'd1,         1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
      '{ROW_REQ, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 7'd4, 1'b0}},
      '{ROW_REQ, 32'h8000_0001, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_threshold(directed_rows[r].ip[STRIKE_W-1:0]);
      end else begin
        send_req(directed_rows[r].ip, directed_rows[r].found, directed_rows[r].typed,
                 directed_rows[r].want);
      end
    end
    known_ips.push_back(32'h0000_0000);
    known_ips.push_back(32'hFFFF_FFFF);
    known_ips.push_back(32'h8000_0001);
    known_ips.push_back(32'h1234_5678);

    run_phase(STRIKE_W'($urandom_range(10, 2)), 6, 320, 60, 0);
    // Two addresses hammered at the top threshold so their counts reach 127,
    // with neither side ever idling.
    calm = 1'b1;
    run_phase(7'd127, 2, 360, 95, 0);
    calm = 1'b0;
    run_phase(7'd1, 8, 120, 50, 0);
    run_phase(STRIKE_W'($urandom_range(127, 1)), 5, 250, 55, 0);
    // Fresh addresses fill the remaining slots, after which inserts fail.
    run_phase(STRIKE_W'($urandom_range(20, 2)), 3, 350, 60, 45);

    settle();
    repeat (TABLE_SIZE + 8) @(posedge clk);
    if (errors == 0) begin
      $display("** ip_strike_ban_table_unit: PASSED **");
    end else begin
      $display("** ip_strike_ban_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ipsb_pkg.sv
rtl/ipsb_ifs.sv
rtl/ipsb_ram.sv
rtl/ip_strike_ban_table_unit.sv
bench/tb_ip_strike_ban_table_unit.sv
